FILE: hdl/buddy_block_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// Buddy block allocator assertion macros
// Shared property wrappers for the allocator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Sequencer states and fixed constants of the allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int FM_WORD_W = 32;   // free-map bits per memory word
   localparam int FM_BIT_W  = 5;    // bit index within a word
   localparam int WANT_W    = 5;    // level computed from a 16-bit size

   localparam logic CMD_ALLOC  = 1'b0;
   localparam logic CMD_FREE   = 1'b1;
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_OOM = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SPLIT_RD,
      ST_SPLIT_WR,
      ST_LVL_WR,
      ST_FREE_LVL,
      ST_MERGE_RD,
      ST_MERGE_CHK,
      ST_SET_RD,
      ST_SET_WR
   } bba_state_type;

endpackage

FILE: hdl/bba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/buddy_block_allocator_top.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Power-of-two heap allocator with free map and level store in RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each gives one
// result, shown for one cycle with rsp_strobe, which the receiver must take
// then. The free map is a RAM of 32-bit words, one bit per buddy-tree node,
// and each access is a read followed by a write, so the free-map port sets
// the rate. An allocate reads each map word it scans (from the wanted level
// up, lowest address first), reads and writes the map for each split, then
// writes the level store; a request larger than the top block skips the
// scan. A free reads the level store, checks each buddy in turn, merging
// while it is free, then marks the block. After reset a clearing pass writes
// all ceil((2^LEVELS-1)/32) map words (128 by default) with busy high.
`include "buddy_block_allocator_top_defines.svh"

module buddy_block_allocator_top
   import bba_pkg::*;
#(
   parameter int LEVELS         = 12,
   parameter int MIN_BLOCK_LOG2 = 4,
   parameter int HEADER_BYTES   = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [15:0] req_size,
   input  logic [14:0] req_free_addr,
   output logic        rsp_strobe,
   output logic        rsp_status,
   output logic [14:0] rsp_alloc_addr,
   output logic [3:0]  rsp_block_level
);

   localparam int NODE_COUNT = (1 << LEVELS) - 1;
   localparam int FM_WORDS   = (NODE_COUNT + FM_WORD_W - 1) / FM_WORD_W;
   localparam int FM_AW      = (FM_WORDS > 1) ? $clog2(FM_WORDS) : 1;
   localparam int NW         = (LEVELS < 6) ? 6 : LEVELS;
   localparam int BW         = LEVELS - 1;
   localparam int LVW        = $clog2(LEVELS + 1);
   localparam int SW         = $clog2(LEVELS);
   localparam int HAW        = BW + MIN_BLOCK_LOG2;

   // first node index of a level; the last one is twice that
   function automatic logic [NW-1:0] lvl_lo(input logic [LVW-1:0] l);
      logic [NW-1:0] r;
      r = (NW'(1) << (LEVELS - 1 - int'(l))) - NW'(1);
      return r;
   endfunction

   function automatic logic [NW-1:0] node_of(input logic [LVW-1:0] l,
                                             input logic [BW-1:0]  b);
      logic [NW-1:0] lo;
      lo = lvl_lo(l);
      return lo + (NW'(b) & lo);
   endfunction

   bba_state_type state_ff, state_in;
   logic [LVW-1:0]   lvl_ff, lvl_in, want_ff, want_in;
   logic [BW-1:0]    blk_ff, blk_in;
   logic [FM_AW-1:0] word_ff, word_in, end_word_ff, end_word_in, clr_ff, clr_in;
   logic [HAW-1:0]   baddr_ff, baddr_in;
   logic             rsp_strobe_ff, rsp_strobe_in, rsp_status_ff, rsp_status_in;
   logic [14:0]      rsp_alloc_addr_ff, rsp_alloc_addr_in;
   logic [3:0]       rsp_block_level_ff, rsp_block_level_in;

   logic                 fm_wr_en, fm_rd_en;
   logic [FM_AW-1:0]     fm_wr_addr, fm_rd_addr;
   logic [FM_WORD_W-1:0] fm_wr_data, fm_rd_data;
   logic                 ls_wr_en, ls_rd_en;
   logic [BW-1:0]        ls_wr_addr, ls_rd_addr;
   logic [SW-1:0]        ls_wr_data, ls_rd_data;

   logic                 accept;
   logic [16:0]          total, total_m1;
   logic [WANT_W-1:0]    want_c, k_c;
   logic                 too_large;
   logic [NW-1:0]        lo_cur, hi_cur, lo_want, lo_next, n_bit, hit_node, node_sel;
   logic [FM_WORD_W-1:0] scan_mask;
   logic                 hit;
   logic [FM_BIT_W-1:0]  hit_bit, bit_sel;
   logic [FM_AW-1:0]     word_sel;
   logic [BW-1:0]        sel_blk, hit_blk;
   logic                 last_lvl, split_more, sel_free;
   logic [HAW-1:0]       f_baddr, a_baddr;
   logic [LVW-1:0]       f_lvl;
   logic [BW-1:0]        a_idx;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // wanted level: ceil(log2(size + header)) above the minimum block
   always_comb begin
      total    = 17'(req_size) + 17'(HEADER_BYTES);
      total_m1 = total - 17'd1;
      k_c      = '0;
      for (int i = 0; i < 17; i++) begin
         if (total_m1[i]) begin
            k_c = WANT_W'(i + 1);
         end
      end
      if (int'(k_c) < MIN_BLOCK_LOG2) begin
         want_c = '0;
      end else begin
         want_c = WANT_W'(int'(k_c) - MIN_BLOCK_LOG2);
      end
      too_large = (int'(want_c) >= LEVELS);
   end

   // level scan over the current map word
   always_comb begin
      lo_cur  = lvl_lo(lvl_ff);
      hi_cur  = lo_cur << 1;
      lo_want = lvl_lo(LVW'(want_c));
      lo_next = lvl_lo(lvl_ff + LVW'(1));
      for (int b = 0; b < FM_WORD_W; b++) begin
         n_bit        = NW'({word_ff, FM_BIT_W'(b)});
         scan_mask[b] = fm_rd_data[b] && (n_bit >= lo_cur) && (n_bit <= hi_cur);
      end
      hit     = |scan_mask;
      hit_bit = '0;
      for (int b = FM_WORD_W - 1; b >= 0; b--) begin
         if (scan_mask[b]) begin
            hit_bit = FM_BIT_W'(b);
         end
      end
      hit_node   = NW'({word_ff, hit_bit});
      hit_blk    = BW'(hit_node - lo_cur);
      last_lvl   = (lvl_ff == LVW'(LEVELS - 1));
      split_more = (lvl_ff > want_ff);
   end

   // node addressed by the split, merge and mark steps
   always_comb begin
      unique case (state_ff)
         ST_SPLIT_RD, ST_SPLIT_WR: sel_blk = blk_ff | BW'(1);
         ST_MERGE_RD, ST_MERGE_CHK: sel_blk = blk_ff ^ BW'(1);
         default: sel_blk = blk_ff;
      endcase
      node_sel = node_of(lvl_ff, sel_blk);
      bit_sel  = node_sel[FM_BIT_W-1:0];
      word_sel = FM_AW'(node_sel >> FM_BIT_W);
      sel_free = fm_rd_data[bit_sel];
   end

   always_comb begin
      f_baddr = HAW'(32'(req_free_addr) - 32'(HEADER_BYTES));
      if (int'(ls_rd_data) >= LEVELS) begin
         f_lvl = LVW'(LEVELS - 1);
      end else begin
         f_lvl = LVW'(ls_rd_data);
      end
      a_idx   = BW'(blk_ff << want_ff);
      a_baddr = {a_idx, {MIN_BLOCK_LOG2{1'b0}}};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == FM_AW'(FM_WORDS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_FREE) state_in = ST_FREE_LVL;
               else if (!too_large)     state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            priority if (hit) begin
               state_in = split_more ? ST_SPLIT_RD : ST_LVL_WR;
            end else if (word_ff == end_word_ff && last_lvl) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SPLIT_RD: state_in = ST_SPLIT_WR;
         ST_SPLIT_WR: state_in = split_more ? ST_SPLIT_RD : ST_LVL_WR;
         ST_LVL_WR:   state_in = ST_IDLE;
         ST_FREE_LVL: begin
            state_in = (int'(f_lvl) < LEVELS - 1) ? ST_MERGE_RD : ST_SET_RD;
         end
         ST_MERGE_RD: state_in = ST_MERGE_CHK;
         ST_MERGE_CHK: begin
            if (sel_free && (int'(lvl_ff) + 1 < LEVELS - 1)) state_in = ST_MERGE_RD;
            else                                           state_in = ST_SET_RD;
         end
         ST_SET_RD: state_in = ST_SET_WR;
         ST_SET_WR: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      lvl_in             = lvl_ff;
      want_in            = want_ff;
      blk_in             = blk_ff;
      word_in            = word_ff;
      end_word_in        = end_word_ff;
      clr_in             = clr_ff;
      baddr_in           = baddr_ff;
      rsp_strobe_in      = 1'b0;
      rsp_status_in      = rsp_status_ff;
      rsp_alloc_addr_in  = rsp_alloc_addr_ff;
      rsp_block_level_in = rsp_block_level_ff;
      fm_wr_en   = 1'b0;
      fm_wr_addr = word_sel;
      fm_wr_data = fm_rd_data;
      fm_rd_en   = 1'b0;
      fm_rd_addr = word_sel;
      ls_wr_en   = 1'b0;
      ls_wr_addr = a_idx;
      ls_wr_data = SW'(want_ff);
      ls_rd_en   = 1'b0;
      ls_rd_addr = BW'(f_baddr >> MIN_BLOCK_LOG2);
      unique case (state_ff)
         ST_CLEAR: begin
            fm_wr_en   = 1'b1;
            fm_wr_addr = clr_ff;
            fm_wr_data = (clr_ff == '0) ? FM_WORD_W'(1) : '0;  // only the top node free
            clr_in     = clr_ff + FM_AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_FREE) begin
                  ls_rd_en = 1'b1;
                  baddr_in = f_baddr;
               end else if (too_large) begin
                  rsp_strobe_in      = 1'b1;
                  rsp_status_in      = STATUS_OOM;
                  rsp_alloc_addr_in  = '0;
                  rsp_block_level_in = '0;
               end else begin
                  want_in     = LVW'(want_c);
                  lvl_in      = LVW'(want_c);
                  word_in     = FM_AW'(lo_want >> FM_BIT_W);
                  end_word_in = FM_AW'((lo_want << 1) >> FM_BIT_W);
               end
            end
         end
         ST_SCAN_RD: begin
            fm_rd_en   = 1'b1;
            fm_rd_addr = word_ff;
         end
         ST_SCAN_CHK: begin
            priority if (hit) begin
               fm_wr_en   = 1'b1;
               fm_wr_addr = word_ff;
               fm_wr_data = fm_rd_data & ~(FM_WORD_W'(1) << hit_bit);
               if (split_more) begin
                  lvl_in = lvl_ff - LVW'(1);
                  blk_in = hit_blk << 1;
               end else begin
                  blk_in = hit_blk;
               end
            end else if (word_ff == end_word_ff) begin
               if (last_lvl) begin
                  rsp_strobe_in      = 1'b1;
                  rsp_status_in      = STATUS_OOM;
                  rsp_alloc_addr_in  = '0;
                  rsp_block_level_in = '0;
               end else begin
                  lvl_in      = lvl_ff + LVW'(1);
                  word_in     = FM_AW'(lo_next >> FM_BIT_W);
                  end_word_in = FM_AW'((lo_next << 1) >> FM_BIT_W);
               end
            end else begin
               word_in = word_ff + FM_AW'(1);
            end
         end
         ST_SPLIT_RD: fm_rd_en = 1'b1;
         ST_SPLIT_WR: begin
            // upper half of the split becomes free
            fm_wr_en   = 1'b1;
            fm_wr_data = fm_rd_data | (FM_WORD_W'(1) << bit_sel);
            if (split_more) begin
               lvl_in = lvl_ff - LVW'(1);
               blk_in = blk_ff << 1;
            end
         end
         ST_LVL_WR: begin
            ls_wr_en           = 1'b1;
            rsp_strobe_in      = 1'b1;
            rsp_status_in      = STATUS_OK;
            rsp_alloc_addr_in  = 15'(a_baddr + HAW'(HEADER_BYTES));
            rsp_block_level_in = 4'(want_ff);
         end
         ST_FREE_LVL: begin
            lvl_in = f_lvl;
            blk_in = BW'(baddr_ff >> (int'(f_lvl) + MIN_BLOCK_LOG2));
         end
         ST_MERGE_RD: fm_rd_en = 1'b1;
         ST_MERGE_CHK: begin
            if (sel_free) begin
               fm_wr_en   = 1'b1;
               fm_wr_data = fm_rd_data & ~(FM_WORD_W'(1) << bit_sel);
               blk_in     = blk_ff >> 1;
               lvl_in     = lvl_ff + LVW'(1);
            end
         end
         ST_SET_RD: fm_rd_en = 1'b1;
         ST_SET_WR: begin
            fm_wr_en           = 1'b1;
            fm_wr_data         = fm_rd_data | (FM_WORD_W'(1) << bit_sel);
            rsp_strobe_in      = 1'b1;
            rsp_status_in      = STATUS_OK;
            rsp_alloc_addr_in  = '0;
            rsp_block_level_in = 4'(lvl_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff             <= lvl_in;
      want_ff            <= want_in;
      blk_ff             <= blk_in;
      word_ff            <= word_in;
      end_word_ff        <= end_word_in;
      baddr_ff           <= baddr_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_alloc_addr_ff  <= rsp_alloc_addr_in;
      rsp_block_level_ff <= rsp_block_level_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_alloc_addr  = rsp_alloc_addr_ff;
   assign rsp_block_level = rsp_block_level_ff;

   bba_ram #(.WIDTH(FM_WORD_W), .DEPTH(FM_WORDS)) u_free_map (
      .clock   (clock),
      .wr_en   (fm_wr_en),
      .wr_addr (fm_wr_addr),
      .wr_data (fm_wr_data),
      .rd_en   (fm_rd_en),
      .rd_addr (fm_rd_addr),
      .rd_data (fm_rd_data)
   );

   bba_ram #(.WIDTH(SW), .DEPTH(1 << BW)) u_level_store (
      .clock   (clock),
      .wr_en   (ls_wr_en),
      .wr_addr (ls_wr_addr),
      .wr_data (ls_wr_data),
      .rd_en   (ls_rd_en),
      .rd_addr (ls_rd_addr),
      .rd_data (ls_rd_data)
   );

   `BBA_ASSERT_NEXT(a_accept_busy, clock, reset, accept && !(req_cmd == CMD_ALLOC && too_large), busy, "request accepted but block not busy")
   `BBA_ASSERT_NOW(a_oom_zero, clock, reset, rsp_strobe && rsp_status == STATUS_OOM, rsp_alloc_addr == '0 && rsp_block_level == '0, "failed request with nonzero payload")
   `BBA_ASSERT_NOW(a_clear_busy, clock, reset, state_ff == ST_CLEAR, busy && !fm_rd_en, "request possible during clearing pass")
   `BBA_ASSERT_NOW(a_fm_port, clock, reset, fm_wr_en, !fm_rd_en, "free map read and written in one cycle")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Sends allocate and free requests, keeps its own copy of the free map and
// level store, and checks each response against the predicted one.
// ----------------------------------------------------------------------------
module tb;
   import bba_pkg::*;

   localparam int NUM_LVL  = 12;
   localparam int MIN_LOG2 = 4;
   localparam int HDR      = 4;
   localparam int TOP_LVL  = NUM_LVL - 1;
   localparam int NODES    = (1 << NUM_LVL) - 1;
   localparam int MIN_BLKS = 1 << (NUM_LVL - 1);
   localparam int HEAP_SZ  = 1 << (NUM_LVL - 1 + MIN_LOG2);
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic        status;
      logic [14:0] addr;
      logic [3:0]  level;
   } alloc_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_cmd = CMD_ALLOC;
   logic [15:0] req_size = '0;
   logic [14:0] req_free_addr = '0;
   logic        rsp_strobe;
   logic        rsp_status;
   logic [14:0] rsp_alloc_addr;
   logic [3:0]  rsp_block_level;

   bit            map_free [NODES];
   logic [3:0]    lvl_rec [MIN_BLKS];
   bit            lvl_set [MIN_BLKS];
   int            set_idx[$];
   logic [14:0]   live_addr[$];
   alloc_rsp_type pending_rsp[$];

   int errors = 0;
   int quiet_cycles = 0;
   int n_alloc = 0, n_free = 0, n_oom = 0, n_checked = 0;
   int idle_pct = 0;

   buddy_block_allocator_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_size(req_size), .req_free_addr(req_free_addr),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_alloc_addr(rsp_alloc_addr), .rsp_block_level(rsp_block_level)
   );

   always #6 clock = ~clock;

   function automatic int node_idx(int lvl, int blk);
      int cnt;
      cnt = 1 << (TOP_LVL - lvl);
      return (cnt - 1) + (blk & (cnt - 1));
   endfunction

   // Updates the heap copy and returns the response a request should give.
   function automatic alloc_rsp_type heap_update(logic cmd, logic [15:0] sz,
                                                 logic [14:0] fa);
      alloc_rsp_type r;
      int total, k, want, lvl, blk, cnt, baddr, idx;
      bit found;
      r = '{status: STATUS_OOM, addr: '0, level: '0};
      found = 0;
      blk = 0;
      if (cmd == CMD_ALLOC) begin
         total = int'(sz) + HDR;
         k = MIN_LOG2;
         while (k < 31 && (1 << k) < total) k++;
         want = k - MIN_LOG2;
         if (want >= NUM_LVL) return r;
         for (lvl = want; lvl < NUM_LVL && !found; lvl++) begin
            cnt = 1 << (TOP_LVL - lvl);
            for (int i = 0; i < cnt && !found; i++)
               if (map_free[cnt - 1 + i]) begin
                  found = 1;
                  blk = i;
               end
         end
         if (!found) return r;
         lvl--;
         map_free[node_idx(lvl, blk)] = 0;
         while (lvl > want) begin
            lvl--;
            blk = blk << 1;
            map_free[node_idx(lvl, blk + 1)] = 1;
         end
         baddr = blk << (want + MIN_LOG2);
         idx = (baddr >> MIN_LOG2) & (MIN_BLKS - 1);
         lvl_rec[idx] = want[3:0];
         if (!lvl_set[idx]) begin
            lvl_set[idx] = 1;
            set_idx.push_back(idx);
         end
         r.status = STATUS_OK;
         r.addr = 15'(baddr + HDR);
         r.level = want[3:0];
      end else begin
         baddr = (int'(fa) - HDR) & (HEAP_SZ - 1);
         lvl = int'(lvl_rec[(baddr >> MIN_LOG2) & (MIN_BLKS - 1)]);
         if (lvl >= NUM_LVL) lvl = TOP_LVL;
         blk = baddr >> (lvl + MIN_LOG2);
         while (lvl < TOP_LVL && map_free[node_idx(lvl, blk ^ 1)]) begin
            map_free[node_idx(lvl, blk ^ 1)] = 0;
            blk = blk >> 1;
            lvl++;
         end
         map_free[node_idx(lvl, blk)] = 1;
         r.status = STATUS_OK;
         r.level = lvl[3:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
   endtask

   // Drives one request from a falling edge and waits until it is taken.
   task automatic send_request(logic cmd, logic [15:0] sz, logic [14:0] fa);
      alloc_rsp_type r;
      int gap;
      start = 1'b1;
      req_cmd = cmd;
      req_size = sz;
      req_free_addr = fa;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = heap_update(cmd, sz, fa);
      pending_rsp.push_back(r);
      if (cmd == CMD_ALLOC) begin
         n_alloc++;
         if (r.status == STATUS_OK) live_addr.push_back(r.addr);
         else n_oom++;
      end else begin
         n_free++;
      end
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         req_cmd = 1'($urandom);
         req_size = 16'($urandom);
         req_free_addr = 15'($urandom);
         gap = $urandom_range(1, 40);
         repeat (gap) @(negedge clock);
      end
   endtask

   // Offset whose level entry was written earlier; low bits and wrap vary.
   function automatic logic [14:0] recorded_offset();
      int idx;
      idx = set_idx[$urandom_range(set_idx.size() - 1)];
      return 15'(idx * 16 + HDR + $urandom_range(15));
   endfunction

   task automatic free_live(int pos);
      logic [14:0] a;
      a = live_addr[pos];
      live_addr.delete(pos);
      send_request(CMD_FREE, 16'($urandom), a);
   endtask

   task automatic test_directed();
      send_request(CMD_ALLOC, 16'd32764, 15'h7fff); // whole heap, top level
      send_request(CMD_ALLOC, 16'd0, 15'd0);        // no space left
      free_live(0);
      send_request(CMD_ALLOC, 16'd0, 15'h7fff);
      send_request(CMD_ALLOC, 16'd12, 15'd0);       // exact 16 stays level 0
      send_request(CMD_ALLOC, 16'd13, 15'd0);
      send_request(CMD_ALLOC, 16'd28, 15'd0);       // exact 32
      send_request(CMD_ALLOC, 16'd29, 15'd0);
      send_request(CMD_ALLOC, 16'hffff, 15'h7fff);  // too large
      send_request(CMD_ALLOC, 16'd32765, 15'd0);    // just over the top block
      send_request(CMD_FREE, 16'hffff, 15'd27);     // unaligned offset, aligned down
      send_request(CMD_FREE, 16'd0, 15'd20);        // double free
      while (live_addr.size() > 0) free_live(live_addr.size() - 1);
      send_request(CMD_FREE, 16'd0, 15'd4);         // free into the empty heap
      send_request(CMD_ALLOC, 16'd16380, 15'd0);    // half heap
      send_request(CMD_ALLOC, 16'd16380, 15'd0);
      send_request(CMD_ALLOC, 16'd1, 15'd0);
      send_request(CMD_FREE, 16'd0, 15'd16388);     // upper half, buddy still taken
      while (live_addr.size() > 0) free_live($urandom_range(live_addr.size() - 1));
   endtask

   task automatic test_random(int count, int pct);
      int sel;
      logic [15:0] sz;
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(99);
         if (sel < 48 || (sel < 88 && live_addr.size() == 0)) begin
            case ($urandom_range(9))
               0:       sz = 16'($urandom_range(32764));
               1:       sz = 16'($urandom);
               2, 3:    sz = 16'($urandom_range(2000));
               default: sz = 16'($urandom_range(120));
            endcase
            send_request(CMD_ALLOC, sz, 15'($urandom));
         end else if (sel < 88) begin
            free_live($urandom_range(live_addr.size() - 1));
         end else if (set_idx.size() > 0) begin
            send_request(CMD_FREE, 16'($urandom), recorded_offset());
         end else begin
            send_request(CMD_ALLOC, 16'($urandom), 15'($urandom));
         end
      end
   endtask

   always @(posedge clock) begin
      alloc_rsp_type e;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            e = pending_rsp.pop_front();
            n_checked++;
            if (rsp_status !== e.status)
               report_mismatch($sformatf("status %b, want %b", rsp_status, e.status));
            if (rsp_alloc_addr !== e.addr)
               report_mismatch($sformatf("addr %h, want %h", rsp_alloc_addr, e.addr));
            if (rsp_block_level !== e.level)
               report_mismatch($sformatf("level %0d, want %0d", rsp_block_level,
                                         e.level));
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no activity for %0d cycles", STALL_LIMIT);
         $display("[buddy_block_allocator_top] ERROR");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NODES; i++) map_free[i] = 0;
      for (int i = 0; i < MIN_BLKS; i++) begin
         lvl_rec[i] = '0;
         lvl_set[i] = 0;
      end
      map_free[node_idx(TOP_LVL, 0)] = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(230, 8);
      test_random(230, 50);
      test_random(230, 0);
      start = 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("ran %0d allocates (%0d refused) and %0d frees, %0d responses checked",
               n_alloc, n_oom, n_free, n_checked);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("[buddy_block_allocator_top] OK");
      end else begin
         $display("%0d mismatches, %0d responses missing", errors, pending_rsp.size());
         $display("[buddy_block_allocator_top] ERROR");
      end
      $finish;
   end
endmodule

FILE: buddy_block_allocator_top.f
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/buddy_block_allocator_top.sv
tb/tb.sv
